// ===== src/dprk4_pkg.sv =====
// Shared types, constants and fixed-point helpers for the driven pendulum RK4 block.
// Used by the multiplier, the sequencer and the top level; no dependencies.
package dprk4_pkg;

  localparam int MUL_W  = 36;
  localparam int PROD_W = 72;

  typedef logic signed [MUL_W-1:0]  mop_t;
  typedef logic signed [PROD_W-1:0] prod_t;

  // micro operations, one multiply each
  typedef enum logic [4:0] {
    OP_TURN, OP_X, OP_X2,
    OP_S1, OP_S2, OP_S3, OP_S4, OP_S5,
    OP_C1, OP_C2, OP_C3, OP_C4, OP_C5,
    OP_PH, OP_COEF, OP_ACC, OP_KTH, OP_KOM,
    OP_DIVT, OP_DIVO, OP_WRAP1, OP_WRAP2
  } op_t;

  // sequencer to datapath control
  typedef struct packed {
    op_t        op;
    logic       pass;    // 0: angle sine pass, 1: drive phase pass
    logic [1:0] stg;     // runge-kutta stage
    logic       issue;
    logic       wb;
    logic       start;
    logic       commit;
  } ctrl_t;

  // configuration register indexes
  localparam logic [2:0] CFG_TIME_STEP       = 3'd0;
  localparam logic [2:0] CFG_GRAVITY_TERM    = 3'd1;
  localparam logic [2:0] CFG_DRIVE_TERM      = 3'd2;
  localparam logic [2:0] CFG_PHASE_STEP      = 3'd3;
  localparam logic [2:0] CFG_SAMPLE_INTERVAL = 3'd4;

  localparam logic [31:0] RST_TIME_STEP       = 32'd674653;
  localparam logic [31:0] RST_GRAVITY_TERM    = 32'd10276045;
  localparam logic [31:0] RST_DRIVE_TERM      = 32'd335544320;
  localparam logic [31:0] RST_PHASE_STEP      = 32'd4294967;
  localparam logic [15:0] RST_SAMPLE_INTERVAL = 16'd1000;

  // fixed-point constants
  localparam mop_t INV_TWO_PI  = 36'sd683565276;    // 2^32/(2pi)
  localparam mop_t HALF_PI     = 36'sd1686629713;   // pi/2 in Q2.30
  localparam mop_t TWO_PI      = 36'sd105414357;    // 2pi in Q8.24
  localparam mop_t DIV3_RECIP  = 36'sd22906492246;  // ceil(2^36/3)
  localparam mop_t Q30_ONE     = 36'sd1073741824;

  localparam mop_t SIN_K0 = 36'sd2959;
  localparam mop_t SIN_K1 = -36'sd213044;
  localparam mop_t SIN_K2 = 36'sd8947849;
  localparam mop_t SIN_K3 = -36'sd178956971;
  localparam mop_t COS_K0 = -36'sd296;
  localparam mop_t COS_K1 = 36'sd26631;
  localparam mop_t COS_K2 = -36'sd1491308;
  localparam mop_t COS_K3 = 36'sd44739243;
  localparam mop_t COS_K4 = -36'sd536870912;

  localparam prod_t S32_MAX = prod_t'(64'sh7fff_ffff);
  localparam prod_t S32_MIN = prod_t'(-64'sh8000_0000);

  // shift right, round half away from zero
  function automatic prod_t rnd_sh(input prod_t v, input int n);
    prod_t h;
    h = prod_t'(1) <<< (n - 1);
    if (v < 0) h = h - prod_t'(1);
    return (v + h) >>> n;
  endfunction

  function automatic logic signed [31:0] sat32(input prod_t v);
    logic signed [31:0] r;
    if (v > S32_MAX) r = 32'sh7fff_ffff;
    else if (v < S32_MIN) r = 32'sh8000_0000;
    else r = v[31:0];
    return r;
  endfunction

  // clamp to [0, 1.0] in Q2.30
  function automatic logic signed [31:0] clamp_unit(input prod_t v);
    logic signed [31:0] r;
    if (v < 0) r = '0;
    else if (v > prod_t'(Q30_ONE)) r = 32'sh4000_0000;
    else r = v[31:0];
    return r;
  endfunction

endpackage

// ===== src/dprk4_mul.sv =====
// Shared signed multiplier with registered product.
// Depends on dprk4_pkg for operand and product types.
module dprk4_mul import dprk4_pkg::*; (
  input  logic  clk,
  input  logic  en,
  input  mop_t  a,
  input  mop_t  b,
  output prod_t prod_r
);

  prod_t prod_nxt;

  // full product of two 36-bit operands
  assign prod_nxt = prod_t'(a) * prod_t'(b);

  always_ff @(posedge clk) begin
    if (en) prod_r <= prod_nxt;
  end

endmodule

// ===== src/dprk4_seq.sv =====
// Micro-sequencer: steps the shared multiplier through one RK4 step.
// Depends on dprk4_pkg for op codes and the control struct.
module dprk4_seq import dprk4_pkg::*; (
  input  logic  clk,
  input  logic  rst_n,
  input  logic  step_req,
  input  logic  out_busy,
  output logic  ready,
  output ctrl_t ctl
);

  typedef enum logic [3:0] {
    SQ_IDLE  = 4'b0001,
    SQ_ISSUE = 4'b0010,
    SQ_WB    = 4'b0100,
    SQ_DONE  = 4'b1000
  } sq_state_t;

  sq_state_t  state_r, state_nxt;
  op_t        op_r, op_nxt;
  logic       pass_r, pass_nxt;
  logic [1:0] stg_r, stg_nxt;

  // next op and state
  always_comb begin
    state_nxt = state_r;
    op_nxt    = op_r;
    pass_nxt  = pass_r;
    stg_nxt   = stg_r;
    unique case (state_r)
      SQ_IDLE: begin
        if (step_req) begin
          state_nxt = SQ_ISSUE;
          op_nxt    = OP_TURN;
          pass_nxt  = 1'b0;
          stg_nxt   = 2'd0;
        end
      end
      SQ_ISSUE: state_nxt = SQ_WB;
      SQ_WB: begin
        state_nxt = SQ_ISSUE;
        case (op_r)
          OP_C5: begin
            if (pass_r) op_nxt = OP_COEF;
            else op_nxt = OP_PH;
          end
          OP_PH: begin
            op_nxt   = OP_X;
            pass_nxt = 1'b1;
          end
          OP_KOM: begin
            if (stg_r == 2'd3) begin
              op_nxt = OP_DIVT;
            end else begin
              stg_nxt  = stg_r + 2'd1;
              pass_nxt = 1'b0;
              op_nxt   = OP_TURN;
            end
          end
          OP_WRAP2: state_nxt = SQ_DONE;
          default: op_nxt = op_t'(5'(op_r) + 5'd1);
        endcase
      end
      SQ_DONE: begin
        if (!out_busy) state_nxt = SQ_IDLE;
      end
      default: state_nxt = SQ_IDLE;
    endcase
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r <= SQ_IDLE;
      op_r    <= OP_TURN;
      pass_r  <= 1'b0;
      stg_r   <= 2'd0;
    end else begin
      state_r <= state_nxt;
      op_r    <= op_nxt;
      pass_r  <= pass_nxt;
      stg_r   <= stg_nxt;
    end
  end

  // control outputs
  assign ready      = (state_r == SQ_IDLE);
  assign ctl.op     = op_r;
  assign ctl.pass   = pass_r;
  assign ctl.stg    = stg_r;
  assign ctl.issue  = (state_r == SQ_ISSUE);
  assign ctl.wb     = (state_r == SQ_WB);
  assign ctl.start  = (state_r == SQ_IDLE) && step_req;
  assign ctl.commit = (state_r == SQ_DONE) && !out_busy;

endmodule

// ===== src/driven_pendulum_rk4_step.sv =====
// Driven pendulum, one RK4 step per step beat, on one shared 36x36 multiplier.
// Load beat: taken while idle, no result. Step beat: 124 multiply ops, each an
// issue and a writeback state, then a commit once out_ is free; the next beat is
// taken after the commit, which registers a sample on out_ when the interval is due.
// Reset (rst_n low, synchronous) clears state and counters and loads the
// default configuration. Depends on dprk4_pkg, dprk4_mul and dprk4_seq.
module driven_pendulum_rk4_step import dprk4_pkg::*; (
  input  logic               clk,
  input  logic               rst_n,
  input  logic               in_valid,
  output logic               in_ready,
  input  logic               in_func,
  input  logic signed [31:0] in_angle_in,
  input  logic signed [31:0] in_velocity_in,
  output logic               out_valid,
  input  logic               out_ready,
  output logic [31:0]        out_sample_count,
  output logic signed [31:0] out_angle_out,
  output logic [26:0]        out_angle_wrapped,
  output logic signed [31:0] out_velocity_out,
  input  logic               cfg_valid,
  output logic               cfg_ready,
  input  logic [2:0]         cfg_index,
  input  logic [31:0]        cfg_data
);

  ctrl_t ctl;
  logic  in_acc, out_busy;
  mop_t  mul_a, mul_b;
  prod_t prod;

  // configuration
  logic [31:0] ts_r, grav_r, drive_r, ps_r;
  logic [15:0] intv_r;

  // architectural state
  logic signed [31:0] ang_r, ang_nxt, vel_r, vel_nxt;
  logic [31:0]        phase_r, phase_nxt, samples_r, samples_nxt;
  logic [15:0]        steps_r, steps_nxt, steps_inc;

  // work registers
  logic signed [31:0] yt_r, yt_nxt, yo_r, yo_nxt;
  logic [31:0]        u_r, u_nxt;
  logic signed [31:0] x_r, x_nxt, x2_r, x2_nxt, p_r, p_nxt, s_r, s_nxt;
  logic signed [31:0] st_r, st_nxt, cp_r, cp_nxt, acc_r, acc_nxt;
  logic signed [35:0] coef_r, coef_nxt, sth_r, sth_nxt, som_r, som_nxt;
  logic signed [32:0] kth_r, kth_nxt;
  logic [4:0]         q_r, q_nxt;
  logic [26:0]        wrap_r, wrap_nxt;

  // output register
  logic               out_valid_r, out_valid_nxt, emit;
  logic [31:0]        out_cnt_r;
  logic signed [31:0] out_ang_r, out_vel_r;
  logic [26:0]        out_wrap_r;

  // derived values
  logic               fold;
  logic [1:0]         quad;
  logic [29:0]        rr;
  prod_t              r26, r30, r32, qd;
  logic signed [31:0] c_new, ts_v, tc_v, sin_q, cos_q;
  logic signed [32:0] k_new;
  logic               wgt2;
  logic [31:0]        ph_ofs;
  logic [35:0]        sabs_t, sabs_o;
  logic [34:0]        dn_t, dn_o;
  logic signed [32:0] ang_x, aabs;
  logic [33:0]        rem;

  assign in_acc    = in_valid && in_ready;
  assign out_busy  = out_valid_r && !out_ready;
  assign cfg_ready = 1'b1;

  dprk4_seq u_seq (
    .clk      (clk),
    .rst_n    (rst_n),
    .step_req (in_valid && in_func),
    .out_busy (out_busy),
    .ready    (in_ready),
    .ctl      (ctl)
  );

  dprk4_mul u_mul (
    .clk    (clk),
    .en     (ctl.issue),
    .a      (mul_a),
    .b      (mul_b),
    .prod_r (prod)
  );

  // quadrant fold of the turn value
  assign quad = u_r[31:30];
  assign fold = u_r[29];
  assign rr   = fold ? 30'(31'h4000_0000 - {1'b0, u_r[29:0]}) : u_r[29:0];

  // rounded product views
  assign r26 = rnd_sh(prod, 26);
  assign r30 = rnd_sh(prod, 30);
  assign r32 = rnd_sh(prod, 32);
  assign qd  = prod >>> 36;

  // cosine result and quadrant mapping
  always_comb begin
    c_new = clamp_unit(prod_t'(Q30_ONE) + r30);
    ts_v  = fold ? c_new : s_r;
    tc_v  = fold ? s_r : c_new;
    case (quad)
      2'd0: begin sin_q = ts_v;  cos_q = tc_v;  end
      2'd1: begin sin_q = tc_v;  cos_q = -ts_v; end
      2'd2: begin sin_q = -ts_v; cos_q = -tc_v; end
      default: begin sin_q = -tc_v; cos_q = ts_v; end
    endcase
  end

  // stage weights and drive phase offsets
  assign wgt2  = (ctl.stg == 2'd1) || (ctl.stg == 2'd2);
  assign k_new = r32[32:0];
  always_comb begin
    case (ctl.stg)
      2'd0:    ph_ofs = '0;
      2'd3:    ph_ofs = ps_r;
      default: ph_ofs = ps_r >> 1;
    endcase
  end

  // magnitudes for the divide by six and the angle wrap
  assign sabs_t = sth_r[35] ? 36'(-sth_r) : 36'(sth_r);
  assign sabs_o = som_r[35] ? 36'(-som_r) : 36'(som_r);
  assign dn_t   = 35'((sabs_t + 36'd3) >> 1);
  assign dn_o   = 35'((sabs_o + 36'd3) >> 1);
  assign ang_x  = 33'(ang_r);
  assign aabs   = ang_x[32] ? -ang_x : ang_x;
  assign rem    = 34'(aabs) - prod[33:0];

  // multiplier operand select
  always_comb begin
    mul_a = '0;
    mul_b = '0;
    unique case (ctl.op)
      OP_TURN:  begin mul_a = mop_t'(yt_r);         mul_b = INV_TWO_PI; end
      OP_X:     begin mul_a = mop_t'({1'b0, rr});   mul_b = HALF_PI;    end
      OP_X2:    begin mul_a = mop_t'(x_r);          mul_b = mop_t'(x_r); end
      OP_S1:    begin mul_a = mop_t'(x2_r);         mul_b = SIN_K0;     end
      OP_S5:    begin mul_a = mop_t'(x_r);          mul_b = mop_t'(p_r); end
      OP_C1:    begin mul_a = mop_t'(x2_r);         mul_b = COS_K0;     end
      OP_S2, OP_S3, OP_S4, OP_C2, OP_C3, OP_C4, OP_C5: begin
        mul_a = mop_t'(x2_r);
        mul_b = mop_t'(p_r);
      end
      OP_COEF:  begin mul_a = mop_t'({1'b0, drive_r}); mul_b = mop_t'(cp_r); end
      OP_ACC:   begin mul_a = coef_r;               mul_b = mop_t'(st_r); end
      OP_KTH:   begin mul_a = mop_t'(yo_r);         mul_b = mop_t'({1'b0, ts_r}); end
      OP_KOM:   begin mul_a = mop_t'(acc_r);        mul_b = mop_t'({1'b0, ts_r}); end
      OP_DIVT:  begin mul_a = mop_t'({1'b0, dn_t}); mul_b = DIV3_RECIP; end
      OP_DIVO:  begin mul_a = mop_t'({1'b0, dn_o}); mul_b = DIV3_RECIP; end
      OP_WRAP1: begin mul_a = mop_t'(aabs);         mul_b = INV_TWO_PI; end
      OP_WRAP2: begin mul_a = mop_t'({1'b0, q_r});  mul_b = TWO_PI;     end
      default: begin
        mul_a = '0;
        mul_b = '0;
      end
    endcase
  end

  // datapath writeback, load and commit
  always_comb begin
    ang_nxt     = ang_r;
    vel_nxt     = vel_r;
    phase_nxt   = phase_r;
    steps_nxt   = steps_r;
    samples_nxt = samples_r;
    yt_nxt      = yt_r;
    yo_nxt      = yo_r;
    u_nxt       = u_r;
    x_nxt       = x_r;
    x2_nxt      = x2_r;
    p_nxt       = p_r;
    s_nxt       = s_r;
    st_nxt      = st_r;
    cp_nxt      = cp_r;
    acc_nxt     = acc_r;
    coef_nxt    = coef_r;
    kth_nxt     = kth_r;
    sth_nxt     = sth_r;
    som_nxt     = som_r;
    q_nxt       = q_r;
    wrap_nxt    = wrap_r;
    steps_inc   = steps_r + 16'd1;
    emit        = 1'b0;
    out_valid_nxt = out_valid_r && !out_ready;

    if (in_acc && !in_func) begin
      ang_nxt     = in_angle_in;
      vel_nxt     = in_velocity_in;
      phase_nxt   = '0;
      steps_nxt   = '0;
      samples_nxt = '0;
    end

    if (ctl.start) begin
      yt_nxt  = ang_r;
      yo_nxt  = vel_r;
      sth_nxt = '0;
      som_nxt = '0;
    end

    if (ctl.wb) begin
      unique case (ctl.op)
        OP_TURN: u_nxt  = prod[55:24];
        OP_X:    x_nxt  = prod[61:30];
        OP_X2:   x2_nxt = r30[31:0];
        OP_S1:   p_nxt  = 32'(prod_t'(SIN_K1) + r30);
        OP_S2:   p_nxt  = 32'(prod_t'(SIN_K2) + r30);
        OP_S3:   p_nxt  = 32'(prod_t'(SIN_K3) + r30);
        OP_S4:   p_nxt  = 32'(prod_t'(Q30_ONE) + r30);
        OP_S5:   s_nxt  = clamp_unit(r30);
        OP_C1:   p_nxt  = 32'(prod_t'(COS_K1) + r30);
        OP_C2:   p_nxt  = 32'(prod_t'(COS_K2) + r30);
        OP_C3:   p_nxt  = 32'(prod_t'(COS_K3) + r30);
        OP_C4:   p_nxt  = 32'(prod_t'(COS_K4) + r30);
        OP_C5: begin
          if (ctl.pass) cp_nxt = cos_q;
          else st_nxt = sin_q;
        end
        OP_PH:   u_nxt    = phase_r + ph_ofs;
        OP_COEF: coef_nxt = 36'(prod_t'({1'b0, grav_r}) + r30);
        OP_ACC:  acc_nxt  = sat32(-r26);
        OP_KTH: begin
          kth_nxt = k_new;
          sth_nxt = sth_r + (wgt2 ? (36'(k_new) <<< 1) : 36'(k_new));
        end
        OP_KOM: begin
          som_nxt = som_r + (wgt2 ? (36'(k_new) <<< 1) : 36'(k_new));
          if (ctl.stg == 2'd2) begin
            yt_nxt = sat32(prod_t'(ang_r) + prod_t'(kth_r));
            yo_nxt = sat32(prod_t'(vel_r) + prod_t'(k_new));
          end else if (ctl.stg != 2'd3) begin
            yt_nxt = sat32(prod_t'(ang_r) + rnd_sh(prod_t'(kth_r), 1));
            yo_nxt = sat32(prod_t'(vel_r) + rnd_sh(prod_t'(k_new), 1));
          end
        end
        OP_DIVT: ang_nxt = sat32(prod_t'(ang_r) + (sth_r[35] ? -qd : qd));
        OP_DIVO: vel_nxt = sat32(prod_t'(vel_r) + (som_r[35] ? -qd : qd));
        OP_WRAP1: q_nxt = prod[60:56];
        OP_WRAP2: wrap_nxt = (rem >= 34'(TWO_PI)) ? 27'(rem - 34'(TWO_PI)) : rem[26:0];
        default: u_nxt = u_r;
      endcase
    end

    // end of step: phase, counters, sample
    if (ctl.commit) begin
      phase_nxt = phase_r + ps_r;
      if (steps_inc == intv_r) begin
        steps_nxt     = '0;
        samples_nxt   = samples_r + 32'd1;
        emit          = 1'b1;
        out_valid_nxt = 1'b1;
      end else begin
        steps_nxt = steps_inc;
      end
    end
  end

  // control, state and configuration registers
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      ts_r        <= RST_TIME_STEP;
      grav_r      <= RST_GRAVITY_TERM;
      drive_r     <= RST_DRIVE_TERM;
      ps_r        <= RST_PHASE_STEP;
      intv_r      <= RST_SAMPLE_INTERVAL;
      ang_r       <= '0;
      vel_r       <= '0;
      phase_r     <= '0;
      steps_r     <= '0;
      samples_r   <= '0;
      out_valid_r <= 1'b0;
    end else begin
      ang_r       <= ang_nxt;
      vel_r       <= vel_nxt;
      phase_r     <= phase_nxt;
      steps_r     <= steps_nxt;
      samples_r   <= samples_nxt;
      out_valid_r <= out_valid_nxt;
      if (cfg_valid && cfg_ready) begin
        unique case (cfg_index)
          CFG_TIME_STEP:       ts_r    <= cfg_data;
          CFG_GRAVITY_TERM:    grav_r  <= cfg_data;
          CFG_DRIVE_TERM:      drive_r <= cfg_data;
          CFG_PHASE_STEP:      ps_r    <= cfg_data;
          CFG_SAMPLE_INTERVAL: intv_r  <= cfg_data[15:0];
          default:             intv_r  <= intv_r;
        endcase
      end
    end
  end

  // work and output payload registers
  always_ff @(posedge clk) begin
    yt_r   <= yt_nxt;
    yo_r   <= yo_nxt;
    u_r    <= u_nxt;
    x_r    <= x_nxt;
    x2_r   <= x2_nxt;
    p_r    <= p_nxt;
    s_r    <= s_nxt;
    st_r   <= st_nxt;
    cp_r   <= cp_nxt;
    acc_r  <= acc_nxt;
    coef_r <= coef_nxt;
    kth_r  <= kth_nxt;
    sth_r  <= sth_nxt;
    som_r  <= som_nxt;
    q_r    <= q_nxt;
    wrap_r <= wrap_nxt;
    if (emit) begin
      out_cnt_r  <= samples_nxt;
      out_ang_r  <= ang_r;
      out_wrap_r <= wrap_r;
      out_vel_r  <= vel_r;
    end
  end

  assign out_valid         = out_valid_r;
  assign out_sample_count  = out_cnt_r;
  assign out_angle_out     = out_ang_r;
  assign out_angle_wrapped = out_wrap_r;
  assign out_velocity_out  = out_vel_r;

endmodule

// ===== src/dprk4_chk.sv =====
// Port-level checks for driven_pendulum_rk4_step, bound to the top level.
// Depends only on the top level's ports.
module dprk4_chk (
  input logic               clk,
  input logic               rst_n,
  input logic               in_valid,
  input logic               in_ready,
  input logic               in_func,
  input logic               out_valid,
  input logic               out_ready,
  input logic [31:0]        out_sample_count,
  input logic signed [31:0] out_angle_out,
  input logic signed [31:0] out_velocity_out
);

  // a stalled sample beat holds
  a_out_hold: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid && !out_ready |=> out_valid && $stable(out_sample_count) &&
      $stable(out_angle_out) && $stable(out_velocity_out))
    else $error("sample beat changed while stalled");

  // a step beat makes the block busy
  a_step_busy: assert property (@(posedge clk) disable iff (!rst_n)
    in_valid && in_ready && in_func |=> !in_ready)
    else $error("ready after step beat");

  // a load beat leaves the block ready
  a_load_fast: assert property (@(posedge clk) disable iff (!rst_n)
    in_valid && in_ready && !in_func |=> in_ready)
    else $error("busy after load beat");

  // samples only come out of a step in progress
  a_sample_src: assert property (@(posedge clk) disable iff (!rst_n)
    $rose(out_valid) |-> $past(!in_ready))
    else $error("sample without step");

endmodule

bind driven_pendulum_rk4_step dprk4_chk u_chk (.*);

// ===== bench/driven_pendulum_rk4_step_test.sv =====
// Self-checking bench for driven_pendulum_rk4_step: queued load/step beats,
// a fixed-point RK4 predictor and a field-by-field sample checker.
// Depends on dprk4_pkg and the driven_pendulum_rk4_step RTL.
module driven_pendulum_rk4_step_test;
  import dprk4_pkg::*;

  localparam logic FUNC_LOAD = 1'b0;
  localparam logic FUNC_STEP = 1'b1;
  localparam logic [2:0] CFG_UNUSED = 3'd5;
  localparam int SETTLE = 300;

  typedef struct packed {
    logic               func;
    logic signed [31:0] ang;
    logic signed [31:0] vel;
  } beat_t;

  typedef struct packed {
    logic [31:0]        cnt;
    logic signed [31:0] ang;
    logic [26:0]        wrp;
    logic signed [31:0] vel;
  } sample_t;

  logic clk = 1'b0;
  logic rst_n = 1'b0;
  logic in_valid = 1'b0;
  logic in_ready;
  logic in_func = FUNC_LOAD;
  logic signed [31:0] in_angle_in = '0;
  logic signed [31:0] in_velocity_in = '0;
  logic out_valid;
  logic out_ready = 1'b0;
  logic [31:0] out_sample_count;
  logic signed [31:0] out_angle_out;
  logic [26:0] out_angle_wrapped;
  logic signed [31:0] out_velocity_out;
  logic cfg_valid = 1'b0;
  logic cfg_ready;
  logic [2:0] cfg_index = '0;
  logic [31:0] cfg_data = '0;

  beat_t   pending_beats[$];
  sample_t sample_q[$];
  int errors = 0;
  int send_idle = 8;
  int recv_idle = 66;
  logic hold_off = 1'b0;

  // pendulum model state and registers
  logic [31:0] m_dt, m_grav, m_drive, m_pstep;
  logic [15:0] m_interval, m_steps;
  logic signed [31:0] m_theta, m_omega;
  logic [31:0] m_phase, m_samples;

  driven_pendulum_rk4_step uut (.*);

  always #10 clk = ~clk;

  // fixed-point helpers
  function automatic longint rshift_rnd(longint v, int n);
    logic [63:0] m;
    m = v < 0 ? 64'(-v) : 64'(v);
    m = (m + (64'd1 << (n - 1))) >> n;
    return v < 0 ? -longint'(m) : longint'(m);
  endfunction

  function automatic longint clip32(longint v);
    if (v > 64'sh7fffffff) return 64'sh7fffffff;
    if (v < -64'sh80000000) return -64'sh80000000;
    return v;
  endfunction

  function automatic longint q30mul(longint a, longint b);
    return rshift_rnd(a * b, 30);
  endfunction

  function automatic longint unit_clip(longint v);
    if (v < 0) return 0;
    if (v > 64'sd1073741824) return 64'sd1073741824;
    return v;
  endfunction

  function automatic logic [31:0] angle_turns(logic signed [31:0] th);
    logic [63:0] p;
    p = 64'(longint'(th)) * 64'd683565276;
    return p[55:24];
  endfunction

  function automatic void trig(input logic [31:0] u, output longint s_o, output longint c_o);
    logic [1:0] quad;
    logic [63:0] r, rr;
    logic fold;
    longint x, x2, p, s, c, ts, tc;
    quad = u[31:30];
    r = {34'd0, u[29:0]};
    fold = r >= (64'd1 << 29);
    rr = fold ? (64'd1 << 30) - r : r;
    x = longint'((rr * 64'd1686629713) >> 30);
    x2 = q30mul(x, x);
    p = 2959;
    p = -213044 + q30mul(x2, p);
    p = 8947849 + q30mul(x2, p);
    p = -178956971 + q30mul(x2, p);
    p = 64'sd1073741824 + q30mul(x2, p);
    s = unit_clip(q30mul(x, p));
    p = -296;
    p = 26631 + q30mul(x2, p);
    p = -1491308 + q30mul(x2, p);
    p = 44739243 + q30mul(x2, p);
    p = -536870912 + q30mul(x2, p);
    c = unit_clip(64'sd1073741824 + q30mul(x2, p));
    ts = fold ? c : s;
    tc = fold ? s : c;
    case (quad)
      2'd0: begin s_o = ts; c_o = tc; end
      2'd1: begin s_o = tc; c_o = -ts; end
      2'd2: begin s_o = -ts; c_o = -tc; end
      default: begin s_o = -tc; c_o = ts; end
    endcase
  endfunction

  function automatic longint omega_dot(logic signed [31:0] th, logic [31:0] ph);
    longint st, ct, sp, cp, coef;
    trig(angle_turns(th), st, ct);
    trig(ph, sp, cp);
    coef = longint'({32'd0, m_grav}) + rshift_rnd(longint'({32'd0, m_drive}) * cp, 30);
    return clip32(-rshift_rnd(coef * st, 26));
  endfunction

  function automatic longint rk_avg(longint a, longint b, longint c, longint d);
    longint sum;
    logic [63:0] m;
    sum = a + 2 * b + 2 * c + d;
    m = sum < 0 ? 64'(-sum) : 64'(sum);
    m = (m + 64'd3) / 64'd6;
    return sum < 0 ? -longint'(m) : longint'(m);
  endfunction

  // advance the model by one beat; returns 1 when a sample is due
  function automatic bit pendulum_advance(beat_t b, output sample_t smp);
    longint kth[4], kom[4], dt;
    logic signed [31:0] yt, yo;
    logic [31:0] ph[4];
    logic [63:0] mag;
    smp = '0;
    if (b.func == FUNC_LOAD) begin
      m_theta = b.ang;
      m_omega = b.vel;
      m_phase = '0;
      m_steps = '0;
      m_samples = '0;
      return 1'b0;
    end
    dt = longint'({32'd0, m_dt});
    yt = m_theta;
    yo = m_omega;
    ph[0] = m_phase;
    ph[1] = m_phase + (m_pstep >> 1);
    ph[2] = ph[1];
    ph[3] = m_phase + m_pstep;
    for (int i = 0; i < 4; i++) begin
      kth[i] = rshift_rnd(longint'(yo) * dt, 32);
      kom[i] = rshift_rnd(omega_dot(yt, ph[i]) * dt, 32);
      if (i < 2) begin
        yt = 32'(clip32(longint'(m_theta) + rshift_rnd(kth[i], 1)));
        yo = 32'(clip32(longint'(m_omega) + rshift_rnd(kom[i], 1)));
      end else if (i == 2) begin
        yt = 32'(clip32(longint'(m_theta) + kth[i]));
        yo = 32'(clip32(longint'(m_omega) + kom[i]));
      end
    end
    m_theta = 32'(clip32(longint'(m_theta) + rk_avg(kth[0], kth[1], kth[2], kth[3])));
    m_omega = 32'(clip32(longint'(m_omega) + rk_avg(kom[0], kom[1], kom[2], kom[3])));
    m_phase = m_phase + m_pstep;
    m_steps = m_steps + 16'd1;
    if (m_steps != m_interval) return 1'b0;
    m_steps = '0;
    m_samples = m_samples + 32'd1;
    mag = m_theta < 0 ? 64'(-longint'(m_theta)) : 64'(longint'(m_theta));
    smp.cnt = m_samples;
    smp.ang = m_theta;
    smp.wrp = 27'(mag % 64'd105414357);
    smp.vel = m_omega;
    return 1'b1;
  endfunction

  // driver: offers queued beats, predicts on each accepted one
  always @(posedge clk) begin
    beat_t b;
    sample_t smp;
    if (!rst_n) begin
      in_valid <= 1'b0;
    end else begin
      if (in_valid && in_ready) begin
        b = '{in_func, in_angle_in, in_velocity_in};
        if (pendulum_advance(b, smp)) sample_q.push_back(smp);
      end
      if (!in_valid || in_ready) begin
        if (pending_beats.size() != 0 && $urandom_range(99) >= send_idle) begin
          b = pending_beats.pop_front();
          in_func <= b.func;
          in_angle_in <= b.ang;
          in_velocity_in <= b.vel;
          in_valid <= 1'b1;
        end else begin
          in_valid <= 1'b0;
        end
      end
    end
  end

  // monitor: random back-pressure, compares each sample beat
  always @(posedge clk) begin
    sample_t e;
    if (!rst_n) begin
      out_ready <= 1'b0;
    end else begin
      if (out_valid && out_ready) begin
        if (sample_q.size() == 0) begin
          $display("%0t: unexpected sample count=%0d", $time, out_sample_count);
          errors++;
        end else begin
          e = sample_q.pop_front();
          if (out_sample_count !== e.cnt) begin
            $display("%0t: sample_count exp %0d got %0d", $time, e.cnt, out_sample_count);
            errors++;
          end
          if (out_angle_out !== e.ang) begin
            $display("%0t: angle_out exp %0d got %0d", $time, e.ang, out_angle_out);
            errors++;
          end
          if (out_angle_wrapped !== e.wrp) begin
            $display("%0t: angle_wrapped exp %0d got %0d", $time, e.wrp, out_angle_wrapped);
            errors++;
          end
          if (out_velocity_out !== e.vel) begin
            $display("%0t: velocity_out exp %0d got %0d", $time, e.vel, out_velocity_out);
            errors++;
          end
        end
      end
      out_ready <= !hold_off && ($urandom_range(99) >= recv_idle);
    end
  end

  task automatic reg_write(input logic [2:0] idx, input logic [31:0] val);
    @(posedge clk);
    cfg_valid <= 1'b1;
    cfg_index <= idx;
    cfg_data <= val;
    do @(posedge clk); while (!cfg_ready);
    cfg_valid <= 1'b0;
    case (idx)
      CFG_TIME_STEP:       m_dt = val;
      CFG_GRAVITY_TERM:    m_grav = val;
      CFG_DRIVE_TERM:      m_drive = val;
      CFG_PHASE_STEP:      m_pstep = val;
      CFG_SAMPLE_INTERVAL: m_interval = val[15:0];
      default: ;
    endcase
  endtask

  task automatic drain;
    while (pending_beats.size() != 0 || in_valid || sample_q.size() != 0) @(posedge clk);
    repeat (SETTLE) @(posedge clk);
  endtask

  task automatic push(input logic f, input logic [31:0] a, input logic [31:0] v);
    pending_beats.push_back('{f, a, v});
  endtask

  task automatic random_beats(input int n);
    logic [31:0] a, v;
    for (int i = 0; i < n; i++) begin
      if ($urandom_range(9) == 0) begin
        a = $urandom_range(3) == 0 ? $urandom() : 32'($signed($urandom_range(110000000)) - 55000000);
        v = $urandom_range(3) == 0 ? $urandom() : 32'($signed($urandom_range(200000000)) - 100000000);
        push(FUNC_LOAD, a, v);
      end else begin
        push(FUNC_STEP, $urandom(), $urandom());
      end
    end
  endtask

  task automatic random_regs;
    reg_write(CFG_TIME_STEP, $urandom_range(1) ? $urandom_range(32'h0400_0000) : $urandom());
    reg_write(CFG_GRAVITY_TERM, $urandom_range(1) ? $urandom_range(32'h0400_0000) : $urandom());
    reg_write(CFG_DRIVE_TERM, $urandom_range(1) ? $urandom_range(32'h2000_0000) : $urandom());
    reg_write(CFG_PHASE_STEP, $urandom());
    reg_write(CFG_SAMPLE_INTERVAL, $urandom_range(1, 5));
  endtask

  // stimulus phases
  initial begin
    m_dt = RST_TIME_STEP;
    m_grav = RST_GRAVITY_TERM;
    m_drive = RST_DRIVE_TERM;
    m_pstep = RST_PHASE_STEP;
    m_interval = RST_SAMPLE_INTERVAL;
    m_theta = '0;
    m_omega = '0;
    m_phase = '0;
    m_steps = '0;
    m_samples = '0;
    repeat (8) @(posedge clk);
    rst_n <= 1'b1;
    @(posedge clk);

    // default sample interval, steps from reset state, no samples yet
    push(FUNC_STEP, 0, 0);
    push(FUNC_STEP, 32'hffff_ffff, 32'hffff_ffff);
    drain();

    // directed: field extremes with one sample per step
    reg_write(CFG_SAMPLE_INTERVAL, 1);
    push(FUNC_LOAD, 32'h7fff_ffff, 32'h7fff_ffff);
    push(FUNC_STEP, 0, 0);
    push(FUNC_LOAD, 32'h8000_0000, 32'h8000_0000);
    push(FUNC_STEP, 0, 0);
    push(FUNC_LOAD, 0, 0);
    push(FUNC_STEP, 0, 0);
    push(FUNC_LOAD, 32'd52707179, 0);
    push(FUNC_STEP, 0, 0);
    push(FUNC_LOAD, 32'd105414357, 32'hff00_0000);
    push(FUNC_STEP, 0, 0);
    push(FUNC_STEP, 0, 0);
    drain();

    // directed: saturation with every register but the interval at its top
    reg_write(CFG_TIME_STEP, 32'hffff_ffff);
    reg_write(CFG_GRAVITY_TERM, 32'hffff_ffff);
    reg_write(CFG_DRIVE_TERM, 32'hffff_ffff);
    reg_write(CFG_PHASE_STEP, 32'hffff_ffff);
    reg_write(CFG_SAMPLE_INTERVAL, 2);
    push(FUNC_LOAD, 32'h7fff_0000, 32'h7fff_ffff);
    for (int i = 0; i < 4; i++) push(FUNC_STEP, 0, 0);
    push(FUNC_LOAD, 32'h8000_0000, 32'h8000_0000);
    for (int i = 0; i < 4; i++) push(FUNC_STEP, 0, 0);
    drain();

    // the four value registers at zero, plus a write to an unused index
    reg_write(CFG_TIME_STEP, 0);
    reg_write(CFG_GRAVITY_TERM, 0);
    reg_write(CFG_DRIVE_TERM, 0);
    reg_write(CFG_PHASE_STEP, 0);
    reg_write(CFG_UNUSED, 32'hdead_beef);
    reg_write(CFG_SAMPLE_INTERVAL, 3);
    push(FUNC_LOAD, 32'h0123_4567, 32'hfedc_ba98);
    for (int i = 0; i < 6; i++) push(FUNC_STEP, 0, 0);
    drain();

    // zero interval and top interval: no sample within a short run
    reg_write(CFG_TIME_STEP, RST_TIME_STEP);
    reg_write(CFG_SAMPLE_INTERVAL, 0);
    for (int i = 0; i < 4; i++) push(FUNC_STEP, 0, 0);
    drain();
    reg_write(CFG_SAMPLE_INTERVAL, 16'hffff);
    for (int i = 0; i < 4; i++) push(FUNC_STEP, 0, 0);
    drain();
    // interval lowered below the running count, still no sample soon
    reg_write(CFG_SAMPLE_INTERVAL, 2);
    for (int i = 0; i < 3; i++) push(FUNC_STEP, 0, 0);
    drain();

    // random phases, idling patterns rotate
    for (int ph = 0; ph < 12; ph++) begin
      if (ph == 4) begin
        send_idle = 66;
        recv_idle = 8;
      end else if (ph == 8) begin
        send_idle = 0;
        recv_idle = 0;
      end
      random_regs();
      if (ph == 6) begin
        reg_write(CFG_SAMPLE_INTERVAL, 1);
        fork
          begin
            @(posedge clk);
            hold_off <= 1'b1;
            repeat (3000) @(posedge clk);
            hold_off <= 1'b0;
          end
        join_none
      end
      random_beats(38);
      drain();
    end

    if (errors == 0) $display("driven_pendulum_rk4_step regression: pass");
    else $display("driven_pendulum_rk4_step regression: fail");
    $finish;
  end

  // watchdog
  initial begin
    #(20 * 1500000);
    $display("driven_pendulum_rk4_step regression: fail");
    $finish;
  end

endmodule

// ===== files.f =====
src/dprk4_pkg.sv
src/dprk4_mul.sv
src/dprk4_seq.sv
src/driven_pendulum_rk4_step.sv
src/dprk4_chk.sv
bench/driven_pendulum_rk4_step_test.sv
